/* rtl/core/counting_semaphore_wait_queue_defines.svh */
// Assertion macros for the counting semaphore wait queue.
// Expects signals named clock and reset in the module that uses them.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_DEFINES_SVH

// check a property on every clock edge outside reset
`define CSWQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// check that a condition is followed by a consequence in the next clock cycle
`define CSWQ_ASSERT_NEXT(name, cond, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) else $error(msg);

`endif

/* rtl/core/cswq_pkg.sv */
// Shared types and constants for the counting semaphore wait queue.
// No dependencies; imported by cswq_seq and the top module, not by the link RAM.
`timescale 1ns / 1ps

package cswq_pkg;

   localparam int DEFAULT_TASKS       = 16;
   localparam int DEFAULT_COUNT_WIDTH = 16;
   localparam int TASK_ID_W           = 4;
   localparam int REG_W               = 16;
   localparam int COUNT_OUT_W         = 16;
   localparam int CSR_INDEX_W         = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_INIT_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CEILING    = 2'd1;

   typedef enum logic [1:0] {
      KIND_WAIT    = 2'd0,
      KIND_POST    = 2'd1,
      KIND_CANCEL  = 2'd2,
      KIND_DESTROY = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_BLOCK     = 3'd1,
      ST_POSTED    = 3'd2,
      ST_WOKEN     = 3'd3,
      ST_TIMEOUT   = 3'd4,
      ST_ERROR     = 3'd5,
      ST_DESTROYED = 3'd6
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_WALK = 3'b100
   } state_type;

   typedef struct packed {
      kind_type               kind;
      logic [TASK_ID_W-1:0]   task_id;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [TASK_ID_W-1:0]   woken_task;
      logic [COUNT_OUT_W-1:0] count_now;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic make_valid;
   } setup_type;

endpackage

/* rtl/core/cswq_link_ram.sv */
// Synchronous link memory, one write port and one registered read port.
// Holds next or previous pointers of the wait queue; no dependencies.
`timescale 1ns / 1ps

module cswq_link_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int DW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/cswq_seq.sv */
// Request sequencer: count, queue ends, queued bits and result register.
// Uses cswq_pkg, two cswq_link_ram instances and the assertion macros.
`timescale 1ns / 1ps
`include "counting_semaphore_wait_queue_defines.svh"

module cswq_seq #(
   parameter int TASKS       = cswq_pkg::DEFAULT_TASKS,
   parameter int COUNT_WIDTH = cswq_pkg::DEFAULT_COUNT_WIDTH,
   parameter int TW          = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cswq_pkg::setup_type     setup,
   input  logic [COUNT_WIDTH-1:0]  init_count,
   input  logic [COUNT_WIDTH-1:0]  ceiling,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  cswq_pkg::req_type       req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cswq_pkg::rsp_type       rsp_word
);

   import cswq_pkg::*;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   logic [TASK_ID_W-1:0]   tid_ff, tid_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   valid_ff, valid_in;
   logic                   empty_ff, empty_in;
   logic [TW-1:0]          head_ff, head_in;
   logic [TW-1:0]          tail_ff, tail_in;
   logic [TASKS-1:0]       queued_ff, queued_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic          rd_en;
   logic [TW-1:0] rd_addr;
   logic [TW-1:0] next_rd, prev_rd;
   logic          next_we, prev_we;
   logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd;

   logic          req_fire, out_free, tok, t_queued;
   logic [TW-1:0] t_idx, u_idx;
   logic          unlink, emit, emit_last;
   status_type    emit_status;
   logic [TW-1:0] emit_task;

   cswq_link_ram #(.DEPTH(TASKS), .AW(TW), .DW(TW)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_we),
      .wr_addr (next_wa),
      .wr_data (next_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   cswq_link_ram #(.DEPTH(TASKS), .AW(TW), .DW(TW)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign t_idx     = TW'(tid_ff);
   assign tok       = 32'(tid_ff) < TASKS;
   assign t_queued  = tok && queued_ff[t_idx];
   assign u_idx     = (state_ff == S_EXEC && kind_ff == KIND_CANCEL) ? t_idx : head_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      tid_in       = tid_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      empty_in     = empty_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      queued_in    = queued_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = TW'(req_word.task_id);
      next_we      = 1'b0;
      next_wa      = '0;
      next_wd      = '0;
      prev_we      = 1'b0;
      prev_wa      = '0;
      prev_wd      = '0;
      unlink       = 1'b0;
      emit         = 1'b0;
      emit_last    = 1'b1;
      emit_status  = ST_ERROR;
      emit_task    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_word.kind;
               tid_in   = req_word.task_id;
               rd_en    = 1'b1;
               if (req_word.kind == KIND_POST || req_word.kind == KIND_DESTROY) begin
                  rd_addr = head_ff;
               end
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               emit     = 1'b1;
               unique case (kind_ff)
                  KIND_WAIT: begin
                     if (!valid_ff || !tok || t_queued) begin
                        emit_status = ST_ERROR;
                     end else if (count_ff != '0) begin
                        count_in    = count_ff - 1'b1;
                        emit_status = ST_GRANTED;
                     end else begin
                        queued_in[t_idx] = 1'b1;
                        if (empty_ff) begin
                           head_in  = t_idx;
                           empty_in = 1'b0;
                        end else begin
                           next_we = 1'b1;
                           next_wa = tail_ff;
                           next_wd = t_idx;
                           prev_we = 1'b1;
                           prev_wa = t_idx;
                           prev_wd = tail_ff;
                        end
                        tail_in     = t_idx;
                        emit_status = ST_BLOCK;
                     end
                  end
                  KIND_POST: begin
                     if (!valid_ff) begin
                        emit_status = ST_ERROR;
                     end else if (!empty_ff) begin
                        unlink      = 1'b1;
                        emit_status = ST_WOKEN;
                        emit_task   = head_ff;
                     end else begin
                        if (count_ff < ceiling) begin
                           count_in = count_ff + 1'b1;
                        end
                        emit_status = ST_POSTED;
                     end
                  end
                  KIND_CANCEL: begin
                     if (t_queued) begin
                        unlink      = 1'b1;
                        emit_status = ST_TIMEOUT;
                     end else begin
                        emit_status = ST_ERROR;
                     end
                  end
                  KIND_DESTROY: begin
                     if (!valid_ff) begin
                        emit_status = ST_ERROR;
                     end else begin
                        emit     = 1'b0;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     emit_status = ST_ERROR;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (out_free) begin
               emit = 1'b1;
               if (!empty_ff) begin
                  unlink      = 1'b1;
                  emit_status = ST_WOKEN;
                  emit_task   = head_ff;
                  emit_last   = 1'b0;
                  rd_en       = 1'b1;
                  rd_addr     = next_rd;
               end else begin
                  emit_status = ST_DESTROYED;
                  valid_in    = 1'b0;
                  queued_in   = '0;
                  empty_in    = 1'b1;
                  state_in    = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (unlink) begin
         queued_in[u_idx] = 1'b0;
         if (u_idx == head_ff && u_idx == tail_ff) begin
            empty_in = 1'b1;
         end else if (u_idx == head_ff) begin
            head_in = next_rd;
         end else if (u_idx == tail_ff) begin
            tail_in = prev_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
      end

      if (emit) begin
         rsp_valid_in      = 1'b1;
         rsp_in.status     = emit_status;
         rsp_in.woken_task = TASK_ID_W'(emit_task);
         rsp_in.count_now  = COUNT_OUT_W'(count_in);
         rsp_in.last       = emit_last;
      end

      if (setup.load) begin
         count_in  = init_count;
         valid_in  = setup.make_valid;
         empty_in  = 1'b1;
         head_in   = '0;
         tail_in   = '0;
         queued_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         valid_ff     <= 1'b1;
         empty_ff     <= 1'b1;
         head_ff      <= '0;
         tail_ff      <= '0;
         queued_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         empty_ff     <= empty_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         queued_ff    <= queued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      tid_ff  <= tid_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   `CSWQ_ASSERT(a_empty_matches_queued, empty_ff == (queued_ff == '0), "empty flag mismatch")
   `CSWQ_ASSERT(a_ends_queued, !empty_ff |-> (queued_ff[head_ff] && queued_ff[tail_ff]), "bad ends")
   `CSWQ_ASSERT(a_partial_in_walk, (rsp_valid_ff && !rsp_ff.last) |-> (state_ff == S_WALK), "stray")
   `CSWQ_ASSERT(a_count_bounded, valid_ff |-> (count_ff <= ceiling), "count above maximum")
   `CSWQ_ASSERT_NEXT(a_walk_drains, state_ff == S_WALK && out_free && !empty_ff && head_ff == tail_ff, empty_ff, "stuck")

endmodule

/* rtl/core/counting_semaphore_wait_queue.sv */
// Counting semaphore with a FIFO wait queue of task numbers. A wait, post or
// timeout cancel reads the next and previous links of the addressed task (the
// queue head for a post), then, once the result register is free, updates
// the queue ends and writes the links back. A destroy wakes the queued tasks
// in turn, paced by the read of the next link of the head. The result register
// lets the next request be accepted while a result still waits to be taken.
// A write to either count register reloads the count, empties the queue
// and sets the block valid when the initial count does not exceed the maximum;
// the link memories need no clearing pass. Write registers only while idle.
`timescale 1ns / 1ps

module counting_semaphore_wait_queue #(
   parameter int TASKS       = cswq_pkg::DEFAULT_TASKS,
   parameter int COUNT_WIDTH = cswq_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [cswq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cswq_pkg::REG_W-1:0]           csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  cswq_pkg::req_type                    req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output cswq_pkg::rsp_type                    rsp_word
);

   import cswq_pkg::*;

   localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
   localparam logic [32:0] COUNT_LIMIT = (33'd1 << COUNT_WIDTH) - 33'd1;

   function automatic logic [COUNT_WIDTH-1:0] sat_count(input logic [REG_W-1:0] v);
      return (33'(v) > COUNT_LIMIT) ? '1 : COUNT_WIDTH'(v);
   endfunction

   logic [REG_W-1:0]       init_reg_ff, init_reg_in;
   logic [REG_W-1:0]       max_reg_ff, max_reg_in;
   logic [COUNT_WIDTH-1:0] init_sat, max_sat;
   setup_type              setup;

   always_comb begin
      init_reg_in = init_reg_ff;
      max_reg_in  = max_reg_ff;
      setup.load  = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_INIT_COUNT: begin
               init_reg_in = csr_wdata;
               setup.load  = 1'b1;
            end
            CSR_CEILING: begin
               max_reg_in = csr_wdata;
               setup.load = 1'b1;
            end
            default: begin
               setup.load = 1'b0;
            end
         endcase
      end
      init_sat         = sat_count(init_reg_in);
      setup.make_valid = init_sat <= sat_count(max_reg_in);
      max_sat          = sat_count(max_reg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_reg_ff <= '0;
         max_reg_ff  <= REG_W'(1);
      end else begin
         init_reg_ff <= init_reg_in;
         max_reg_ff  <= max_reg_in;
      end
   end

   cswq_seq #(
      .TASKS       (TASKS),
      .COUNT_WIDTH (COUNT_WIDTH),
      .TW          (TW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .setup      (setup),
      .init_count (init_sat),
      .ceiling    (max_sat),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

endmodule
